// ===== hdl/jac_pkg.sv =====
// Package for the joystick axis conditioner.
// Holds shared constants, register indexes and default parameter values.
// No dependencies.
package jac_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int FRACTION_BITS_DEF = 16;

   // fixed field widths
   localparam int PCT_W   = 8;
   localparam int TIME_W  = 32;
   localparam int ALPHA_W = 16;
   localparam int RATE_W  = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAL_MIN    = 3'd0,
      REG_CAL_CENTER = 3'd1,
      REG_CAL_MAX    = 3'd2,
      REG_DEAD_ZONE  = 3'd3,
      REG_INVERT     = 3'd4,
      REG_ALPHA      = 3'd5,
      REG_SLEW_RATE  = 3'd6
   } csr_reg_type;

   // register reset values that do not depend on the sample width
   localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd3277;
   localparam logic [RATE_W-1:0]  RATE_RST  = 16'd180;

   // mapping
   localparam int MAP_Q_W  = 7;      // quotient bits of the mapping division
   localparam int PCT_FULL = 100;

   // slew limit: rate (pct/s) * dt (ms) / 1000
   localparam int SLEW_DIV     = 1000;
   localparam int SLEW_REM_W   = 10;  // remainder below SLEW_DIV
   localparam int PROD_SAT     = 200000;
   localparam int PROD_W       = 18;  // unsaturated product bits
   localparam int MAX_STEP_PCT = 200;

endpackage

// ===== hdl/jac_if.sv =====
// Handshake channels of the joystick axis conditioner.
// Request carries one raw axis item, response one conditioned item; uses jac_pkg.
interface jac_req_if #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
);
   import jac_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TIME_W-1:0]      now_ms;
   logic                   restart;

   modport source (output valid, sample, now_ms, restart, input ready);
   modport sink   (input valid, sample, now_ms, restart, output ready);
endinterface

interface jac_rsp_if;
   import jac_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PCT_W-1:0] command_percent;
   logic signed [PCT_W-1:0] mapped_percent;

   modport source (output valid, command_percent, mapped_percent, input ready);
   modport sink   (input valid, command_percent, mapped_percent, output ready);
endinterface

// ===== hdl/joystick_axis_conditioner_unit.sv =====
// Joystick axis conditioner: calibration map, deadzone, smoother, slew limiter.
// Seeding items go from the mapping divide straight to the filter update; other items run
// the 16-step serial multipliers and, unless the slew product saturates, the bit-serial
// divide by 1000. One item at a time; the next item is accepted once the result has loaded,
// and a finished item waits in the output register.
// Reset (synchronous, active high) restores register defaults and unseeds the filter.
module joystick_axis_conditioner_unit #(
   parameter int SAMPLE_BITS   = jac_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = jac_pkg::FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   jac_req_if.sink                         req_ch,
   jac_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [jac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import jac_pkg::*;

   localparam int SB      = SAMPLE_BITS;
   localparam int F       = FRACTION_BITS;
   localparam int VAL_W   = F + 9;
   localparam int STEP_W  = F + 8;
   localparam int SPAN_W  = SB + 2;
   localparam int NUM_W   = SB + 7;
   localparam int DIV_W   = PROD_W + F;
   localparam int CNT_W   = $clog2(DIV_W + 1);
   localparam int AMUL_W  = STEP_W + ALPHA_W;
   localparam int RMUL_W  = TIME_W + RATE_W;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MAP  = 9'b000000010,
      ST_MDIV = 9'b000000100,
      ST_PREP = 9'b000001000,
      ST_SMUL = 9'b000010000,
      ST_SDIV = 9'b000100000,
      ST_UPD  = 9'b001000000,
      ST_CMD  = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [SB-1:0]      cal_min_ff, cal_center_ff, cal_max_ff, dead_zone_ff;
   logic               invert_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [RATE_W-1:0]  rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_ff    <= '0;
         cal_center_ff <= SB'(1) << (SB - 1);
         cal_max_ff    <= '1;
         dead_zone_ff  <= '0;
         invert_ff     <= 1'b0;
         alpha_ff      <= ALPHA_RST;
         rate_ff       <= RATE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CAL_MIN:    cal_min_ff    <= csr_wdata[SB-1:0];
            REG_CAL_CENTER: cal_center_ff <= csr_wdata[SB-1:0];
            REG_CAL_MAX:    cal_max_ff    <= csr_wdata[SB-1:0];
            REG_DEAD_ZONE:  dead_zone_ff  <= csr_wdata[SB-1:0];
            REG_INVERT:     invert_ff     <= csr_wdata[0];
            REG_ALPHA:      alpha_ff      <= csr_wdata[ALPHA_W-1:0];
            REG_SLEW_RATE:  rate_ff       <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // item and datapath registers
   logic [SB-1:0]            sample_ff, sample_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic                     restart_ff, restart_in;
   logic                     neg_ff, neg_in, in_dz_ff, in_dz_in, full_ff, full_in;
   logic [NUM_W-1:0]         rem_ff, rem_in, dsr_ff, dsr_in;
   logic [MAP_Q_W-1:0]       q_ff, q_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [PCT_W-1:0]  mapped_ff, mapped_in;
   logic                     dneg_ff, dneg_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [STEP_W-1:0]        maxstep_ff, maxstep_in;
   logic [DIV_W-1:0]         dvd_ff, dvd_in;
   logic [SLEW_REM_W-1:0]    r1k_ff, r1k_in;
   logic signed [VAL_W-1:0]  smooth_ff, smooth_in, cmd_ff, cmd_in;
   logic                     seeded_ff, seeded_in;
   logic [TIME_W-1:0]        last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PCT_W-1:0]  rsp_cmd_ff, rsp_cmd_in, rsp_map_ff, rsp_map_in;

   // mapping front end
   logic signed [SB:0]       c_s, c_neg;
   logic [SB-1:0]            mag, excess;
   logic                     pos;
   logic signed [SPAN_W-1:0] span_s;
   logic [NUM_W-1:0]         num;

   always_comb begin
      c_s    = $signed({1'b0, sample_ff}) - $signed({1'b0, cal_center_ff});
      c_neg  = -c_s;
      mag    = c_s[SB] ? c_neg[SB-1:0] : c_s[SB-1:0];
      pos    = !c_s[SB] && (c_s != '0);
      if (pos) begin
         span_s = $signed({2'b00, cal_max_ff}) - $signed({2'b00, cal_center_ff})
                  - $signed({2'b00, dead_zone_ff});
      end else begin
         span_s = $signed({2'b00, cal_center_ff}) - $signed({2'b00, cal_min_ff})
                  - $signed({2'b00, dead_zone_ff});
      end
      excess = mag - dead_zone_ff;
      // excess * 100 as shift-adds
      num    = ({7'b0, excess} << 6) + ({7'b0, excess} << 5) + ({7'b0, excess} << 2);
   end

   // mapped percent from the division result (next quotient, so the last bit counts)
   logic [MAP_Q_W-1:0]      mmag;
   logic signed [PCT_W-1:0] mapped_now;

   always_comb begin
      if (in_dz_ff)      mmag = '0;
      else if (full_ff)  mmag = MAP_Q_W'(PCT_FULL);
      else               mmag = q_in;
      mapped_now = (neg_ff ^ invert_ff) ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
   end

   // filter arithmetic
   logic signed [VAL_W-1:0] target;
   logic signed [VAL_W:0]   diff, dabs;
   logic [TIME_W-1:0]       dt_raw, dt;
   logic                    mul_start, amul_done, rmul_done;
   logic [AMUL_W-1:0]       aprod;
   logic [RMUL_W-1:0]       rprod;
   logic [AMUL_W:0]         asum;
   logic [SLEW_REM_W:0]     t1k;
   logic                    ge1k;
   logic signed [VAL_W:0]   delta, lim, nlim;
   logic [VAL_W-1:0]        cmag;
   logic [VAL_W:0]          rsum;
   logic [VAL_W-F:0]        rint;
   logic [PCT_W-1:0]        rclamp;
   logic                    seed;

   always_comb begin
      target = $signed({{(VAL_W-PCT_W-F){mapped_ff[PCT_W-1]}}, mapped_ff, {F{1'b0}}});
      diff   = {target[VAL_W-1], target} - {smooth_ff[VAL_W-1], smooth_ff};
      dabs   = diff[VAL_W] ? -diff : diff;
      dt_raw = now_ff - last_ff;
      dt     = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
      asum   = {1'b0, aprod} + (AMUL_W+1)'(32768);
      t1k    = {r1k_ff, dvd_ff[DIV_W-1]};
      ge1k   = t1k >= (SLEW_REM_W+1)'(SLEW_DIV);
      delta  = {smooth_ff[VAL_W-1], smooth_ff} - {cmd_ff[VAL_W-1], cmd_ff};
      lim    = $signed({2'b00, maxstep_ff});
      nlim   = -lim;
      cmag   = cmd_ff[VAL_W-1] ? VAL_W'(-cmd_ff) : VAL_W'(cmd_ff);
      rsum   = {1'b0, cmag} + ((VAL_W+1)'(1) << (F - 1));
      rint   = rsum[VAL_W:F];
      rclamp = (rint > (VAL_W-F+1)'(PCT_FULL)) ? PCT_W'(PCT_FULL) : rint[PCT_W-1:0];
      seed   = !seeded_ff || restart_ff;
   end

   jac_serial_mul #(.AW(STEP_W), .BW(ALPHA_W)) u_alpha_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (dabs[STEP_W-1:0]),
      .b       (alpha_ff),
      .done    (amul_done),
      .product (aprod)
   );

   jac_serial_mul #(.AW(TIME_W), .BW(RATE_W)) u_rate_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (dt),
      .b       (rate_ff),
      .done    (rmul_done),
      .product (rprod)
   );

   assign mul_start    = (state_ff == ST_PREP);
   assign req_ch.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      now_in       = now_ff;
      restart_in   = restart_ff;
      neg_in       = neg_ff;
      in_dz_in     = in_dz_ff;
      full_in      = full_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      mapped_in    = mapped_ff;
      dneg_in      = dneg_ff;
      step_in      = step_ff;
      maxstep_in   = maxstep_ff;
      dvd_in       = dvd_ff;
      r1k_in       = r1k_ff;
      smooth_in    = smooth_ff;
      cmd_in       = cmd_ff;
      seeded_in    = seeded_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_map_in   = rsp_map_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sample_in  = req_ch.sample;
               now_in     = req_ch.now_ms;
               restart_in = req_ch.restart;
               state_in   = ST_MAP;
            end
         end
         ST_MAP: begin
            neg_in   = !pos;
            in_dz_in = mag < dead_zone_ff;
            full_in  = (span_s <= 0) || ($signed({2'b00, excess}) >= span_s);
            rem_in   = num;
            dsr_in   = {1'b0, span_s[SB-1:0], 6'b0};
            q_in     = '0;
            cnt_in   = CNT_W'(MAP_Q_W);
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               q_in   = {q_ff[MAP_Q_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[MAP_Q_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = seed ? ST_UPD : ST_PREP;
            end
         end
         ST_PREP: begin
            mapped_in = mapped_now;
            state_in  = ST_SMUL;
         end
         ST_SMUL: begin
            dneg_in = diff[VAL_W];
            if (amul_done && rmul_done) begin
               step_in = asum[STEP_W+15:16];
               if (rprod >= RMUL_W'(PROD_SAT)) begin
                  maxstep_in = STEP_W'(MAX_STEP_PCT) << F;
                  state_in   = ST_UPD;
               end else begin
                  dvd_in     = {rprod[PROD_W-1:0], {F{1'b0}}};
                  r1k_in     = '0;
                  maxstep_in = '0;
                  cnt_in     = CNT_W'(DIV_W);
                  state_in   = ST_SDIV;
               end
            end
         end
         ST_SDIV: begin
            r1k_in     = ge1k ? SLEW_REM_W'(t1k - (SLEW_REM_W+1)'(SLEW_DIV))
                              : t1k[SLEW_REM_W-1:0];
            maxstep_in = {maxstep_ff[STEP_W-2:0], ge1k};
            dvd_in     = dvd_ff << 1;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) state_in = ST_UPD;
         end
         ST_UPD: begin
            seeded_in = 1'b1;
            last_in   = now_ff;
            if (seed) begin
               smooth_in = target;
               cmd_in    = target;
               state_in  = ST_FIN;
            end else begin
               smooth_in = dneg_ff ? smooth_ff - $signed({1'b0, step_ff})
                                   : smooth_ff + $signed({1'b0, step_ff});
               state_in  = ST_CMD;
            end
         end
         ST_CMD: begin
            if (delta > lim)       cmd_in = cmd_ff + lim[VAL_W-1:0];
            else if (delta < nlim) cmd_in = cmd_ff + nlim[VAL_W-1:0];
            else                   cmd_in = cmd_ff + delta[VAL_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = cmd_ff[VAL_W-1] ? -$signed(rclamp) : $signed(rclamp);
               rsp_map_in   = mapped_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // seeding items skip the prep cycle, so capture the map when the divider ends
      if (state_ff == ST_MDIV && cnt_ff == CNT_W'(1)) mapped_in = mapped_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         last_ff      <= '0;
         smooth_ff    <= '0;
         cmd_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         last_ff      <= last_in;
         smooth_ff    <= smooth_in;
         cmd_ff       <= cmd_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      now_ff     <= now_in;
      restart_ff <= restart_in;
      neg_ff     <= neg_in;
      in_dz_ff   <= in_dz_in;
      full_ff    <= full_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      q_ff       <= q_in;
      mapped_ff  <= mapped_in;
      dneg_ff    <= dneg_in;
      step_ff    <= step_in;
      maxstep_ff <= maxstep_in;
      dvd_ff     <= dvd_in;
      r1k_ff     <= r1k_in;
      rsp_cmd_ff <= rsp_cmd_in;
      rsp_map_ff <= rsp_map_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.command_percent = rsp_cmd_ff;
   assign rsp_ch.mapped_percent  = rsp_map_ff;
endmodule

// ===== hdl/jac_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Unsigned operands; used by the conditioner top level. No dependencies.
module jac_serial_mul #(
   parameter int AW = 32,
   parameter int BW = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [AW-1:0]  a,
   input  logic [BW-1:0]  b,
   output logic           done,
   output logic [AW+BW-1:0] product
);
   localparam int CNT_W = $clog2(BW + 1);

   logic [AW-1:0]    a_ff, a_in;
   logic [BW-1:0]    b_ff, b_in;
   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // shift-add step
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         acc_in = '0;
         cnt_in = CNT_W'(BW);
      end else if (cnt_ff != '0) begin
         acc_in  = (acc_ff << 1) + (b_ff[BW-1] ? {{BW{1'b0}}, a_ff} : '0);
         b_in    = b_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ===== sim/tb.sv =====
// Testbench for joystick_axis_conditioner_unit: calibration map, smoother and slew limiter.
// Drives axis items through jac_req_if, checks jac_rsp_if items against a local predictor.
// Depends on jac_pkg, jac_if and the unit itself.
module tb;
   import jac_pkg::*;

   localparam int SB = SAMPLE_BITS_DEF;
   localparam int FB = FRACTION_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   jac_req_if #(.SAMPLE_BITS(SB)) req_ch ();
   jac_rsp_if rsp_ch ();

   joystick_axis_conditioner_unit #(.SAMPLE_BITS(SB), .FRACTION_BITS(FB)) DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor copy of the registers and filter state
   int unsigned cfg_min, cfg_center, cfg_max, cfg_dead, cfg_inv, cfg_alpha, cfg_rate;
   longint smooth_fx, command_fx;
   bit primed;
   logic [31:0] prev_ms;

   typedef struct packed {
      logic signed [PCT_W-1:0] command_percent;
      logic signed [PCT_W-1:0] mapped_percent;
   } axis_result_type;
   axis_result_type pending_results[$];

   int mismatch_count = 0;
   int idle_count = 0;
   bit idling_on = 1'b1;
   logic [31:0] clock_ms = 0;

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   function automatic int map_percent(input int unsigned raw);
      int c, mag, span, pct;
      c = int'(raw) - int'(cfg_center);
      mag = c < 0 ? -c : c;
      if (mag < int'(cfg_dead)) return 0;
      if (c > 0) span = int'(cfg_max) - int'(cfg_center) - int'(cfg_dead);
      else span = int'(cfg_center) - int'(cfg_min) - int'(cfg_dead);
      if (span <= 0) pct = PCT_FULL;
      else begin
         pct = (mag - int'(cfg_dead)) * PCT_FULL / span;
         if (pct > PCT_FULL) pct = PCT_FULL;
      end
      if (c <= 0) pct = -pct;
      if (cfg_inv != 0) pct = -pct;
      return pct;
   endfunction

   function automatic int round_fx(input longint v);
      longint mag, r;
      mag = v < 0 ? -v : v;
      r = (mag + (longint'(1) << (FB - 1))) >>> FB;
      if (v < 0) r = -r;
      if (r > PCT_FULL) r = PCT_FULL;
      if (r < -PCT_FULL) r = -PCT_FULL;
      return int'(r);
   endfunction

   // advance the filter for one item and return its expected result
   function automatic axis_result_type condition_axis(input int unsigned raw,
                                                      input logic [31:0] ms,
                                                      input bit restart);
      axis_result_type res;
      int pct;
      longint target, diff, dmag, stepv, prod, max_step, delta;
      logic [31:0] dt;
      pct = map_percent(raw);
      target = longint'(pct) <<< FB;
      if (restart) primed = 1'b0;
      if (!primed) begin
         smooth_fx = target;
         command_fx = target;
         primed = 1'b1;
      end else begin
         diff = target - smooth_fx;
         dmag = diff < 0 ? -diff : diff;
         stepv = (dmag * cfg_alpha + 32768) >>> 16;
         smooth_fx += diff < 0 ? -stepv : stepv;
         dt = ms - prev_ms;
         if (dt == 0) dt = 1;
         prod = longint'(cfg_rate) * longint'(dt);
         if (prod >= PROD_SAT) max_step = longint'(MAX_STEP_PCT) <<< FB;
         else max_step = (prod <<< FB) / SLEW_DIV;
         delta = smooth_fx - command_fx;
         if (delta > max_step) delta = max_step;
         if (delta < -max_step) delta = -max_step;
         command_fx += delta;
      end
      prev_ms = ms;
      res.command_percent = PCT_W'(round_fx(command_fx));
      res.mapped_percent = PCT_W'(pct);
      return res;
   endfunction

   task automatic idle_burst();
      if (idling_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic send_item(input int unsigned raw, input logic [31:0] ms, input bit restart);
      idle_burst();
      pending_results.push_back(condition_axis(raw, ms, restart));
      req_ch.valid <= 1'b1;
      req_ch.sample <= raw[SB-1:0];
      req_ch.now_ms <= ms;
      req_ch.restart <= restart;
      do @(posedge clock); while (!req_ch.ready);
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until all results are back, then let the block settle
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable after its last write
   task automatic write_reg(input csr_reg_type idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         REG_CAL_MIN: cfg_min = value & ((1 << SB) - 1);
         REG_CAL_CENTER: cfg_center = value & ((1 << SB) - 1);
         REG_CAL_MAX: cfg_max = value & ((1 << SB) - 1);
         REG_DEAD_ZONE: cfg_dead = value & ((1 << SB) - 1);
         REG_INVERT: cfg_inv = value & 1;
         REG_ALPHA: cfg_alpha = value & 16'hFFFF;
         REG_SLEW_RATE: cfg_rate = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned mn, ctr, mx, dz, inv, alpha, rate);
      drain();
      write_reg(REG_CAL_MIN, mn);
      write_reg(REG_CAL_CENTER, ctr);
      write_reg(REG_CAL_MAX, mx);
      write_reg(REG_DEAD_ZONE, dz);
      write_reg(REG_INVERT, inv);
      write_reg(REG_ALPHA, alpha);
      write_reg(REG_SLEW_RATE, rate);
      csr_we <= 1'b0;
   endtask

   task automatic tick_send(input int unsigned raw, input int unsigned gap, input bit restart);
      clock_ms = clock_ms + gap;
      send_item(raw, clock_ms, restart);
   endtask

   // directed: field extremes, center, deadzone, time wrap and backwards time
   task automatic test_directed();
      tick_send(2048, 0, 1'b0);
      tick_send(4095, 10, 1'b0);
      tick_send(0, 0, 1'b0);
      tick_send(0, 1000, 1'b0);
      tick_send(4095, 5, 1'b1);
      tick_send(2048, 3, 1'b0);
      clock_ms = 32'hFFFF_FFF0;
      tick_send(3000, 0, 1'b0);
      tick_send(1000, 32, 1'b0);
      clock_ms = 32'd5;
      tick_send(4095, 0, 1'b0);
      set_config(1000, 2000, 3000, 200, 1, 65535, 65535);
      tick_send(2000, 1, 1'b1);
      tick_send(2100, 1, 1'b0);
      tick_send(1850, 1, 1'b0);
      tick_send(3500, 1, 1'b0);
      tick_send(0, 1, 1'b0);
      // zero spans, zero alpha and zero rate freeze
      set_config(4095, 0, 0, 0, 0, 0, 0);
      tick_send(0, 1, 1'b1);
      tick_send(4095, 7, 1'b0);
      tick_send(2000, 9, 1'b0);
      set_config(0, 4095, 4095, 4095, 0, 1, 1);
      tick_send(4095, 1, 1'b1);
      tick_send(0, 1, 1'b0);
      tick_send(100, 0, 1'b0);
   endtask

   // random configuration phases with random samples and time steps
   task automatic test_random(input int count);
      int unsigned gap;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 300),
                       $urandom_range(0, 1), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 20);
            2: gap = $urandom_range(20, 3000);
            default: gap = $urandom();
         endcase
         tick_send($urandom_range(0, 4095), gap, $urandom_range(0, 24) == 0);
      end
   endtask

   // realistic calibration, small time steps only
   task automatic test_smooth_ramp(input int count);
      set_config(200, 2048, 3900, 40, 0, 3277, 180);
      for (int i = 0; i < count; i++)
         tick_send($urandom_range(0, 4095), $urandom_range(1, 20), 1'b0);
   endtask

   // checker
   always @(posedge clock) begin
      axis_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected item", rsp_ch.command_percent, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.command_percent !== want.command_percent)
               report("command_percent", rsp_ch.command_percent, want.command_percent);
            if (rsp_ch.mapped_percent !== want.mapped_percent)
               report("mapped_percent", rsp_ch.mapped_percent, want.mapped_percent);
         end
      end
   end

   // response stall bursts
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(1, 6);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any accepted item, response or register write
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.now_ms = '0;
      req_ch.restart = 1'b0;
      cfg_min = 0; cfg_center = 2048; cfg_max = 4095; cfg_dead = 0;
      cfg_inv = 0; cfg_alpha = ALPHA_RST; cfg_rate = RATE_RST;
      smooth_fx = 0; command_fx = 0; primed = 1'b0; prev_ms = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_smooth_ramp(60);
      idling_on = 1'b0;
      test_random(40);
      drain();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
